// ===== rtl/ibf_pkg.sv =====
`default_nettype none

package ibf_pkg;

  // Default table depth
  localparam int ENTRIES_DEF = 64;

  // Operation codes
  localparam logic [1:0] OP_CHECK = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_DEL   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Input transaction
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic       drop;
    logic [1:0] status;
    logic [6:0] entry_count;
  } out_t;

  // One table word: valid flag and stored address
  typedef struct packed {
    logic        vld;
    logic [31:0] addr;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // latch the transaction, restart the scan
    logic sweep;     // write an empty word at the index, advance
    logic scan;      // read the word at the index, advance
    logic finish;    // apply the update, register the result
    logic clr_done;  // register the result of a clear
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic idx_last;  // index points at the last table word
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/ibf_ctrl.sv =====
`default_nettype none

module ibf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              req_clear,
  input  wire ibf_pkg::ctl_sts_t sts,
  output ibf_pkg::ctl_cmd_t      cmd,
  output logic                   busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       emit_r, emit_nxt;  // clear pass was requested by a transaction

  // State register; reset starts with the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          emit_nxt  = 1'b1;
          state_nxt = req_clear ? S_CLR : S_SCAN;
        end
      end
      S_CLR: begin
        cmd.sweep = 1'b1;
        if (sts.idx_last) begin
          cmd.clr_done = emit_r;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_WAIT;
        end
      end
      // last read word is compared here
      S_WAIT: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/ibf_dpath.sv =====
`default_nettype none

module ibf_dpath #(
  parameter int ENTRIES = ibf_pkg::ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ibf_pkg::in_t      in_data,
  input  wire ibf_pkg::ctl_cmd_t cmd,
  output ibf_pkg::ctl_sts_t      sts,
  output logic                   out_valid,
  output ibf_pkg::out_t          out_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Table memory, single port, registered read
  ibf_pkg::entry_t mem [ENTRIES];
  ibf_pkg::entry_t rdata_r;

  logic [IDX_W-1:0] idx_r, cmp_idx_r, hit_idx_r, free_idx_r;
  logic             rd_vld_r, found_r, free_r;
  logic [1:0]       func_r;
  logic [31:0]      key_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  ibf_pkg::out_t    out_data_r;

  logic             idx_last, hit, empty;
  logic             mem_we;
  logic [IDX_W-1:0] mem_addr;
  ibf_pkg::entry_t  mem_wdata;
  logic             add_ok, del_ok;
  logic [1:0]       status;
  logic [CNT_W+6:0] cnt_ext;

  assign idx_last     = (idx_r == IDX_W'(ENTRIES - 1));
  assign sts.idx_last = idx_last;

  // Compare of the word read in the previous cycle
  assign hit   = rd_vld_r && rdata_r.vld && (rdata_r.addr == key_r);
  assign empty = rd_vld_r && !rdata_r.vld;

  // Update decision
  assign add_ok = (func_r == ibf_pkg::OP_ADD) && !found_r && free_r;
  assign del_ok = (func_r == ibf_pkg::OP_DEL) && found_r;

  always_comb begin
    status    = ibf_pkg::ST_DONE;
    count_nxt = count_r;
    case (func_r)
      ibf_pkg::OP_ADD: begin
        if (found_r) begin
          status = ibf_pkg::ST_DUPLICATE;
        end else if (free_r) begin
          count_nxt = count_r + CNT_W'(1);
        end else begin
          status = ibf_pkg::ST_FULL;
        end
      end
      ibf_pkg::OP_DEL: begin
        if (!found_r) begin
          status = ibf_pkg::ST_NOT_FOUND;
        end else if (count_r != '0) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_ext = (CNT_W + 7)'(count_nxt);

  // Memory port mux: sweep and scan use the index, finish uses the slot
  always_comb begin
    mem_we         = cmd.sweep || (cmd.finish && (add_ok || del_ok));
    mem_addr       = idx_r;
    mem_wdata.vld  = 1'b0;
    mem_wdata.addr = key_r;
    if (cmd.finish) begin
      mem_addr      = add_ok ? free_idx_r : hit_idx_r;
      mem_wdata.vld = add_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_data.func;
      key_r  <= in_data.address;
    end
    cmp_idx_r <= idx_r;
    if (hit && !found_r) begin
      hit_idx_r <= cmp_idx_r;
    end
    if (empty && !free_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (cmd.finish) begin
      out_data_r.drop        <= (func_r == ibf_pkg::OP_CHECK) && found_r;
      out_data_r.status      <= status;
      out_data_r.entry_count <= cnt_ext[6:0];
    end else if (cmd.clr_done) begin
      out_data_r <= '{drop: 1'b0, status: ibf_pkg::ST_DONE, entry_count: 7'd0};
    end
  end

  // Control registers: scan index, match flags, count, strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= cmd.scan;
      out_valid_r <= cmd.finish || cmd.clr_done;
      if (cmd.load) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        free_r  <= 1'b0;
      end else begin
        if (cmd.sweep || cmd.scan) begin
          idx_r <= idx_last ? '0 : idx_r + IDX_W'(1);
        end
        if (hit) begin
          found_r <= 1'b1;
        end
        if (empty) begin
          free_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count_r <= count_nxt;
      end else if (cmd.clr_done) begin
        count_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/ipv4_blocklist_filter_unit.sv =====
`default_nettype none

// Check, add and delete scan the whole table before the result strobes; a clear
// strobes once its sweep of the table is done.
// A new transaction is taken only once the last is done; the scan makes one table
// read per cycle on the single-port address memory, and start is taken again at
// the edge that ends the strobe.
// Reset: synchronous, active low; then a clearing pass of the table with busy high.
// The receiver cannot stall: each result is shown for one cycle only.
module ipv4_blocklist_filter_unit #(
  parameter int ENTRIES = ibf_pkg::ENTRIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire ibf_pkg::in_t in_data,
  output logic              out_valid,
  output ibf_pkg::out_t     out_data
);

  ibf_pkg::ctl_cmd_t cmd;
  ibf_pkg::ctl_sts_t sts;

  // Sequencer
  ibf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_clear (in_data.func == ibf_pkg::OP_CLEAR),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Table and result datapath
  ibf_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // A result only follows a cycle of work
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  // Drop is only reported with a done status
  a_drop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ibf_pkg::ST_DONE)) |-> !out_data.drop)
    else $error("drop reported with non-done status");

  // A taken transaction keeps the unit busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transaction taken but unit not busy");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

module tb;

  localparam int ENTRIES     = ibf_pkg::ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 96;
  localparam int PHASE_ITEMS = 75;

  // Blocklist predictor and expected-result store
  class blocklist_scoreboard;
    logic [31:0]   slot_addr[ENTRIES];
    bit            slot_used[ENTRIES];
    int unsigned   n_stored;
    ibf_pkg::out_t expected_q[$];
    int            errors;

    function new();
      n_stored = 0;
      errors   = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // slot holding addr, or -1
    function int find_addr(logic [31:0] addr);
      foreach (slot_used[i]) begin
        if (slot_used[i] && slot_addr[i] == addr) return i;
      end
      return -1;
    endfunction

    // lowest free slot, or -1 when full
    function int lowest_free();
      foreach (slot_used[i]) begin
        if (!slot_used[i]) return i;
      end
      return -1;
    endfunction

    // update the table copy and queue the decision for an accepted transaction
    function void note_input(ibf_pkg::in_t t);
      ibf_pkg::out_t r;
      int            s;
      r = '0;
      r.status = ibf_pkg::ST_DONE;
      case (t.func)
        ibf_pkg::OP_CHECK: begin
          r.drop = (find_addr(t.address) >= 0);
        end
        ibf_pkg::OP_ADD: begin
          if (find_addr(t.address) >= 0) begin
            r.status = ibf_pkg::ST_DUPLICATE;
          end else begin
            s = lowest_free();
            if (s < 0) begin
              r.status = ibf_pkg::ST_FULL;
            end else begin
              slot_addr[s] = t.address;
              slot_used[s] = 1'b1;
              n_stored++;
            end
          end
        end
        ibf_pkg::OP_DEL: begin
          s = find_addr(t.address);
          if (s < 0) begin
            r.status = ibf_pkg::ST_NOT_FOUND;
          end else begin
            slot_used[s] = 1'b0;
            if (n_stored > 0) n_stored--;
          end
        end
        default: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
          n_stored = 0;
        end
      endcase
      r.entry_count = n_stored[6:0];
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH @%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      errors++;
    endtask

    // compare one result against the oldest expectation
    task check_result(ibf_pkg::out_t got);
      ibf_pkg::out_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result, drop/status/count", {22'd0, got}, 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (got.drop !== want.drop) report("drop", 32'(got.drop), 32'(want.drop));
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.entry_count !== want.entry_count)
          report("entry_count", 32'(got.entry_count), 32'(want.entry_count));
      end
    endtask
  endclass

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  ibf_pkg::in_t  in_data;
  logic          out_valid;
  ibf_pkg::out_t out_data;

  blocklist_scoreboard sb;
  logic [31:0]         addr_pool[POOL_SIZE];
  int                  cycles;

  ipv4_blocklist_filter_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  function ibf_pkg::in_t mk(logic [1:0] f, logic [31:0] a);
    ibf_pkg::in_t t;
    t.func    = f;
    t.address = a;
    return t;
  endfunction

  // issue one transaction after a random gap; returns at the falling edge after acceptance
  task send(ibf_pkg::in_t t);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    in_data = t;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_input(t);
    @(negedge clk);
  endtask

  // hold off the sender until every expected result is back
  task drain();
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // operation mix per phase: fill phases push the table to full
  function logic [1:0] pick_func(int phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      1, 4: begin
        if (r < 75) return ibf_pkg::OP_ADD;
        if (r < 90) return ibf_pkg::OP_CHECK;
        if (r < 99) return ibf_pkg::OP_DEL;
        return ibf_pkg::OP_CLEAR;
      end
      2: begin
        if (r < 45) return ibf_pkg::OP_ADD;
        if (r < 85) return ibf_pkg::OP_CHECK;
        return ibf_pkg::OP_DEL;
      end
      3: begin
        if (r < 55) return ibf_pkg::OP_DEL;
        if (r < 88) return ibf_pkg::OP_CHECK;
        return ibf_pkg::OP_ADD;
      end
      default: begin
        if (r < 50) return ibf_pkg::OP_CHECK;
        if (r < 75) return ibf_pkg::OP_ADD;
        if (r < 96) return ibf_pkg::OP_DEL;
        return ibf_pkg::OP_CLEAR;
      end
    endcase
  endfunction

  function logic [31:0] pick_addr();
    if ($urandom_range(0, 9) < 8) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // stimulus
  initial begin
    sb      = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, extremes, duplicates, misses, slot reuse, clears
    send(mk(ibf_pkg::OP_CHECK, 32'h0000_0000));
    send(mk(ibf_pkg::OP_CHECK, 32'hFFFF_FFFF));
    send(mk(ibf_pkg::OP_DEL,   32'h0000_0000));
    send(mk(ibf_pkg::OP_CLEAR, 32'h0000_0000));
    send(mk(ibf_pkg::OP_ADD,   32'h0000_0000));
    send(mk(ibf_pkg::OP_ADD,   32'hFFFF_FFFF));
    send(mk(ibf_pkg::OP_ADD,   32'h0000_0000));
    send(mk(ibf_pkg::OP_CHECK, 32'h0000_0000));
    send(mk(ibf_pkg::OP_CHECK, 32'hFFFF_FFFF));
    send(mk(ibf_pkg::OP_CHECK, 32'h0000_0001));
    send(mk(ibf_pkg::OP_ADD,   32'h8000_0000));
    send(mk(ibf_pkg::OP_DEL,   32'hFFFF_FFFF));
    send(mk(ibf_pkg::OP_CHECK, 32'hFFFF_FFFF));
    send(mk(ibf_pkg::OP_DEL,   32'hFFFF_FFFF));
    send(mk(ibf_pkg::OP_ADD,   32'hFFFF_FFFE));
    send(mk(ibf_pkg::OP_CHECK, 32'h8000_0000));
    send(mk(ibf_pkg::OP_CHECK, 32'h7FFF_FFFF));
    send(mk(ibf_pkg::OP_CLEAR, 32'hFFFF_FFFF));
    send(mk(ibf_pkg::OP_CHECK, 32'h0000_0000));
    send(mk(ibf_pkg::OP_ADD,   32'hA5A5_5A5A));
    send(mk(ibf_pkg::OP_DEL,   32'hA5A5_5A5A));
    drain();

    // random phases: mixed, fill, full stress, drain down, refill, mixed
    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < PHASE_ITEMS; k++) send(mk(pick_func(ph), pick_addr()));
      if (ph == 2) drain();
    end
    start = 1'b0;

    // wait out the last results, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
    if (sb.pending() != 0) sb.report("results never seen", 32'(sb.pending()), 32'd0);

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
